// ===== rtl/sdht_pkg.sv =====
package sdht_pkg;

   localparam int SLOTS = 32;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam bit SLOTS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);

   // exact width of lip + lport + rip + rport
   localparam int SUM_W = 34;
   localparam int DIGIT_W = 8;
   localparam int HASH_STEPS = (SUM_W + DIGIT_W - 1) / DIGIT_W;
   localparam int PAD_W = HASH_STEPS * DIGIT_W;
   localparam int STEP_W = $clog2(HASH_STEPS + 1);

   // table entry: valid bit over owner id
   localparam int ID_W = 8;
   localparam int ENTRY_W = ID_W + 1;

   typedef enum logic [2:0] {
      OP_REG_LISTENER = 3'd0,
      OP_REG_CONN     = 3'd1,
      OP_REM_LISTENER = 3'd2,
      OP_REM_CONN     = 3'd3,
      OP_LOOKUP       = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_TAKEN = 2'd1,
      ST_MISS  = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0]      operation;
      logic [31:0]     near_addr;
      logic [15:0]     near_port;
      logic [31:0]     far_addr;
      logic [15:0]     far_port;
      logic [ID_W-1:0] socket_id;
   } req_type;

   typedef struct packed {
      logic [1:0]      status;
      logic [ID_W-1:0] found_id;
      logic            found_in_listener;
   } rsp_type;

endpackage

// ===== rtl/sdht_req_if.sv =====
interface sdht_req_if
   import sdht_pkg::*;
   ();
   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/sdht_rsp_if.sv =====
interface sdht_rsp_if
   import sdht_pkg::*;
   ();
   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/sdht_ram.sv =====
module sdht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/socket_demux_hash_table.sv =====
// Channel   Role    Handshake        Payload
// req_bus   sink    valid / ready    operation, tuple, socket_id
// rsp_bus   source  valid / ready    status, found_id, found_in_listener
//
// A request passes accept, table read, and update and response when SLOTS is
// a power of two, else S_HASH comes after accept: the slot modulo runs one
// 8-bit digit per cycle. The table RAMs read through a register. After reset
// a clearing pass writes every slot of both tables with req_bus.ready low.
// A stalled response holds the update step; the next request is taken while
// a response waits in the output register.
module socket_demux_hash_table
   import sdht_pkg::*;
(
   input logic        clock,
   input logic        reset,
   sdht_req_if.sink   req_bus,
   sdht_rsp_if.source rsp_bus
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_READ,
      S_DONE
   } state_type;

   localparam logic [SLOT_W:0] SLOTS_EXT = (SLOT_W + 1)'(SLOTS);

   state_type           state_ff, state_in;
   logic [SLOT_W-1:0]   clr_ff, clr_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic [2:0]          op_ff, op_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [PAD_W-1:0]    lsh_ff, lsh_in;
   logic [PAD_W-1:0]    csh_ff, csh_in;
   logic [SLOT_W-1:0]   lslot_ff, lslot_in;
   logic [SLOT_W-1:0]   cslot_ff, cslot_in;

   logic [SUM_W-1:0]    lsum, csum;
   logic                accept, done_go;
   logic [ENTRY_W-1:0]  l_rd, c_rd;
   logic                l_we, c_we;
   logic [SLOT_W-1:0]   l_waddr, c_waddr;
   logic [ENTRY_W-1:0]  l_wdata, c_wdata;
   logic                l_upd, c_upd;
   logic [ENTRY_W-1:0]  l_upd_data, c_upd_data;
   rsp_type             result;

   // shift one digit into a remainder kept below SLOTS
   function automatic logic [SLOT_W-1:0] mod_digit(input logic [SLOT_W-1:0]  rem,
                                                   input logic [DIGIT_W-1:0] digit);
      logic [SLOT_W:0] acc;
      acc = {1'b0, rem};
      for (int i = DIGIT_W - 1; i >= 0; i--) begin
         acc = {acc[SLOT_W-1:0], digit[i]};
         if (acc >= SLOTS_EXT) begin
            acc = acc - SLOTS_EXT;
         end
      end
      return acc[SLOT_W-1:0];
   endfunction

   assign lsum = SUM_W'(req_bus.payload.near_addr) + SUM_W'(req_bus.payload.near_port);
   assign csum = lsum + SUM_W'(req_bus.payload.far_addr)
               + SUM_W'(req_bus.payload.far_port);

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept = req_bus.valid && req_bus.ready;
   assign done_go = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   sdht_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_listener_ram (
      .clock   (clock),
      .wr_en   (l_we),
      .wr_addr (l_waddr),
      .wr_data (l_wdata),
      .rd_addr (lslot_ff),
      .rd_data (l_rd)
   );

   sdht_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_connection_ram (
      .clock   (clock),
      .wr_en   (c_we),
      .wr_addr (c_waddr),
      .wr_data (c_wdata),
      .rd_addr (cslot_ff),
      .rd_data (c_rd)
   );

   // table update and response for the request in S_DONE
   always_comb begin
      l_upd = 1'b0;
      c_upd = 1'b0;
      l_upd_data = {1'b1, id_ff};
      c_upd_data = {1'b1, id_ff};
      result.status = ST_OK;
      result.found_id = '0;
      result.found_in_listener = 1'b0;
      case (op_ff)
         OP_REG_LISTENER: begin
            if (l_rd[ID_W] && (l_rd[ID_W-1:0] != id_ff)) begin
               result.status = ST_TAKEN;
            end else begin
               l_upd = 1'b1;
            end
         end
         OP_REG_CONN: begin
            if (c_rd[ID_W] && (c_rd[ID_W-1:0] != id_ff)) begin
               result.status = ST_TAKEN;
            end else begin
               c_upd = 1'b1;
            end
         end
         OP_REM_LISTENER: begin
            l_upd = l_rd[ID_W] && (l_rd[ID_W-1:0] == id_ff);
            l_upd_data = '0;
         end
         OP_REM_CONN: begin
            c_upd = c_rd[ID_W] && (c_rd[ID_W-1:0] == id_ff);
            c_upd_data = '0;
         end
         OP_LOOKUP: begin
            if (c_rd[ID_W]) begin
               result.found_id = c_rd[ID_W-1:0];
            end else if (l_rd[ID_W]) begin
               result.found_id = l_rd[ID_W-1:0];
               result.found_in_listener = 1'b1;
            end else begin
               result.status = ST_MISS;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (state_ff == S_CLEAR) begin
         l_we = 1'b1;
         c_we = 1'b1;
         l_waddr = clr_ff;
         c_waddr = clr_ff;
         l_wdata = '0;
         c_wdata = '0;
      end else begin
         l_we = done_go && l_upd;
         c_we = done_go && c_upd;
         l_waddr = lslot_ff;
         c_waddr = cslot_ff;
         l_wdata = l_upd_data;
         c_wdata = c_upd_data;
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      step_in = step_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      op_in = op_ff;
      id_in = id_ff;
      lsh_in = lsh_ff;
      csh_in = csh_ff;
      lslot_in = lslot_ff;
      cslot_in = cslot_ff;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == SLOT_W'(SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               op_in = req_bus.payload.operation;
               id_in = req_bus.payload.socket_id;
               lsh_in = PAD_W'(lsum);
               csh_in = PAD_W'(csum);
               step_in = '0;
               if (SLOTS_POW2) begin
                  lslot_in = lsum[SLOT_W-1:0];
                  cslot_in = csum[SLOT_W-1:0];
                  state_in = S_READ;
               end else begin
                  lslot_in = '0;
                  cslot_in = '0;
                  state_in = S_HASH;
               end
            end
         end
         S_HASH: begin
            lslot_in = mod_digit(lslot_ff, lsh_ff[PAD_W-1 -: DIGIT_W]);
            cslot_in = mod_digit(cslot_ff, csh_ff[PAD_W-1 -: DIGIT_W]);
            lsh_in = lsh_ff << DIGIT_W;
            csh_in = csh_ff << DIGIT_W;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(HASH_STEPS - 1)) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (done_go) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = result;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      op_ff <= op_in;
      id_ff <= id_in;
      lsh_ff <= lsh_in;
      csh_ff <= csh_in;
      lslot_ff <= lslot_in;
      cslot_ff <= cslot_in;
      step_ff <= step_in;
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.payload = rsp_data_ff;

endmodule
